// ===== hw/rtl/keyed_deque_with_search_defines.svh =====
// Assertion macros used by the checker file of the keyed deque.
// No dependencies; include by bare file name.
`ifndef KEYED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define KEYED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Property that must hold on every clock edge outside reset
`define KDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define KDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kdq_pkg.sv =====
// Shared types and codes for the keyed deque with search.
// No dependencies.
`default_nettype none

package kdq_pkg;

	// Request codes
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_SEARCH     = 3'd4;
	localparam logic [2:0] REQ_CREDIT     = 3'd5;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_MISS  = 2'd3;

	localparam int unsigned KEY_W   = 31;
	localparam int unsigned BAL_W   = 32;
	localparam int unsigned CNT_OUT_W = 5;

	localparam logic [15:0] CREDIT_RESET = 16'd100;
	localparam logic [BAL_W-1:0] BAL_MAX = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_FINISH
	} state_t;

	// Write strobes into the record store
	typedef struct packed {
		logic key;
		logic bal;
	} mem_we_t;

	// Compare / saturating add unit result
	typedef struct packed {
		logic             match;
		logic [BAL_W-1:0] sat_bal;
	} alu_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kdq_store.sv =====
// Record store: key and balance arrays, one write port, one registered read port.
// Depends on kdq_pkg.
`default_nettype none

module kdq_store
	import kdq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  mem_we_t          we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [KEY_W-1:0] wr_key,
	input  logic [BAL_W-1:0] wr_bal,
	input  logic [AW-1:0]    rd_addr,
	output logic [KEY_W-1:0] rd_key,
	output logic [BAL_W-1:0] rd_bal
);

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [BAL_W-1:0] bal_mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we.key) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (we.bal) begin
			bal_mem[wr_addr] <= wr_bal;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_bal <= bal_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/kdq_alu.sv =====
// Shared compare and saturating-add unit used by every scan step.
// Depends on kdq_pkg.
`default_nettype none

module kdq_alu
	import kdq_pkg::*;
(
	input  logic [KEY_W-1:0] rd_key,
	input  logic [KEY_W-1:0] ref_key,
	input  logic [BAL_W-1:0] rd_bal,
	input  logic [15:0]      credit,
	output alu_res_t         res
);

	logic [BAL_W:0] sum;

	// Signed balance plus unsigned credit, one extra bit for overflow
	assign sum = {rd_bal[BAL_W-1], rd_bal} + {{(BAL_W-15){1'b0}}, credit};

	assign res.match   = (rd_key == ref_key);
	// only positive overflow is possible
	assign res.sat_bal = (sum[BAL_W:BAL_W-1] == 2'b01) ? BAL_MAX : sum[BAL_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/kdq_ctrl.sv =====
// Sequencer of the keyed deque: ring pointers, scan walk and result register.
// Depends on kdq_pkg; drives kdq_store and reads kdq_alu.
`default_nettype none

module kdq_ctrl
	import kdq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned PW       = 4,
	parameter int unsigned CW       = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       req_type,
	input  logic [KEY_W-1:0] key,
	input  logic [BAL_W-1:0] new_balance,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [BAL_W-1:0] balance,
	output logic [CNT_OUT_W-1:0] count,
	// store
	output mem_we_t          mem_we,
	output logic [PW-1:0]    wr_addr,
	output logic [KEY_W-1:0] wr_key,
	output logic [BAL_W-1:0] wr_bal,
	output logic [PW-1:0]    rd_addr,
	input  logic [BAL_W-1:0] rd_bal,
	// compare unit
	output logic [KEY_W-1:0] ref_key,
	input  alu_res_t         alu_res
);

	localparam int unsigned SW = CW + 1;
	localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	state_t state_q, state_d;

	logic [2:0]       req_q, req_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [BAL_W-1:0] nbal_q, nbal_d;
	logic [PW-1:0]    front_q, front_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [PW-1:0]    scan_pos_q, scan_pos_d;
	logic [CW-1:0]    scan_idx_q, scan_idx_d;
	logic [1:0]       res_status_q, res_status_d;
	logic [BAL_W-1:0] res_bal_q, res_bal_d;
	logic             out_valid_q, out_valid_d;
	logic [1:0]       out_status_q, out_status_d;
	logic [BAL_W-1:0] out_bal_q, out_bal_d;
	logic [CW-1:0]    out_cnt_q, out_cnt_d;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	// Ring position helpers
	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
		return (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
		return (p == '0) ? LAST_POS : p - 1'b1;
	endfunction

	// front + count, wrapped by one compare and subtract
	function automatic logic [PW-1:0] pos_back(input logic [PW-1:0] f, input logic [CW-1:0] c);
		logic [SW-1:0] s;
		s = SW'(f) + SW'(c);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return s[PW-1:0];
	endfunction

	// State and data registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q        <= req_d;
		key_q        <= key_d;
		nbal_q       <= nbal_d;
		scan_pos_q   <= scan_pos_d;
		scan_idx_q   <= scan_idx_d;
		res_status_q <= res_status_d;
		res_bal_q    <= res_bal_d;
		out_status_q <= out_status_d;
		out_bal_q    <= out_bal_d;
		out_cnt_q    <= out_cnt_d;
	end

	// Next state and outputs
	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		key_d        = key_q;
		nbal_d       = nbal_q;
		front_d      = front_q;
		cnt_d        = cnt_q;
		scan_pos_d   = scan_pos_q;
		scan_idx_d   = scan_idx_q;
		res_status_d = res_status_q;
		res_bal_d    = res_bal_q;
		out_status_d = out_status_q;
		out_bal_d    = out_bal_q;
		out_cnt_d    = out_cnt_q;
		out_valid_d  = out_valid_q && out_stall;
		in_stall     = 1'b1;
		mem_we       = '0;
		wr_addr      = scan_pos_q;
		wr_key       = key_q;
		wr_bal       = nbal_q;
		rd_addr      = scan_pos_q;

		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					req_d   = req_type;
					key_d   = key;
					nbal_d  = new_balance;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_status_d = STAT_OK;
				res_bal_d    = '0;
				state_d      = S_FINISH;
				case (req_q)
					REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
						if (cnt_q == FULL_CNT) begin
							res_status_d = STAT_FULL;
						end else begin
							mem_we = '{key: 1'b1, bal: 1'b1};
							if (req_q == REQ_PUSH_BACK) begin
								wr_addr = pos_back(front_q, cnt_q);
							end else begin
								wr_addr = pos_dec(front_q);
								front_d = pos_dec(front_q);
							end
							cnt_d = cnt_q + 1'b1;
						end
					end
					REQ_POP_FRONT, REQ_POP_BACK: begin
						if (cnt_q == '0) begin
							res_status_d = STAT_EMPTY;
						end else begin
							if (req_q == REQ_POP_FRONT) begin
								front_d = pos_inc(front_q);
							end
							cnt_d = cnt_q - 1'b1;
						end
					end
					REQ_SEARCH, REQ_CREDIT: begin
						if (cnt_q == '0) begin
							res_status_d = STAT_MISS;
						end else begin
							// start the walk at the front
							rd_addr    = front_q;
							scan_pos_d = front_q;
							scan_idx_d = '0;
							state_d    = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (alu_res.match) begin
					res_status_d = STAT_OK;
					if (req_q == REQ_CREDIT) begin
						mem_we.bal = 1'b1;
						wr_bal     = alu_res.sat_bal;
						res_bal_d  = alu_res.sat_bal;
					end else begin
						res_bal_d = rd_bal;
					end
					state_d = S_FINISH;
				end else if (scan_idx_q + 1'b1 == cnt_q) begin
					res_status_d = STAT_MISS;
					res_bal_d    = '0;
					state_d      = S_FINISH;
				end else begin
					rd_addr    = pos_inc(scan_pos_q);
					scan_pos_d = pos_inc(scan_pos_q);
					scan_idx_d = scan_idx_q + 1'b1;
				end
			end
			S_FINISH: begin
				// load the result register once it is free
				if (!out_valid_q || !out_stall) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_bal_d    = res_bal_q;
					out_cnt_d    = cnt_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign ref_key   = key_q;
	assign cnt_ext   = (CW + CNT_OUT_W)'(out_cnt_q);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign balance   = out_bal_q;
	assign count     = cnt_ext[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_deque_with_search.sv =====
// Top level of the keyed deque with search: credit register and unit wiring.
// Depends on kdq_pkg, kdq_store, kdq_alu and kdq_ctrl.
//
//   channel   handshake            payload
//   request   in_valid / in_stall  req_type, key, new_balance
//   result    out_valid / out_stall status, balance, count
//   config    cfg_wr_en            cfg_wr_data (credit_amount)
//
// Push, pop and unused codes: dispatch, then finish registers the result and
// returns to idle, where the next request is taken.
// Search and credit: dispatch, one scan step per entry compared, then finish;
// entries compared: 0 when empty, else 1..count; the single read port feeds one per cycle.
// Reset clears pointers, count, sequencer and sets credit to 100; the store
// is not cleared. A result held by out_stall holds the next one in finish.
`default_nettype none

module keyed_deque_with_search
	import kdq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           req_type,
	input  logic [KEY_W-1:0]     key,
	input  logic signed [BAL_W-1:0] new_balance,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic signed [BAL_W-1:0] balance,
	output logic [CNT_OUT_W-1:0] count,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data
);

	localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [15:0]      credit_q;
	mem_we_t          mem_we;
	logic [PW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [BAL_W-1:0] wr_bal;
	logic [PW-1:0]    rd_addr;
	logic [KEY_W-1:0] rd_key;
	logic [BAL_W-1:0] rd_bal;
	logic [KEY_W-1:0] ref_key;
	alu_res_t         alu_res;
	logic [BAL_W-1:0] bal_out;

	// Credit amount register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CREDIT_RESET;
		end else if (cfg_wr_en) begin
			credit_q <= cfg_wr_data;
		end
	end

	kdq_store #(
		.DEPTH (CAPACITY),
		.AW    (PW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_bal  (wr_bal),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_bal  (rd_bal)
	);

	kdq_alu u_alu (
		.rd_key  (rd_key),
		.ref_key (ref_key),
		.rd_bal  (rd_bal),
		.credit  (credit_q),
		.res     (alu_res)
	);

	kdq_ctrl #(
		.CAPACITY (CAPACITY),
		.PW       (PW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key         (key),
		.new_balance (new_balance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.balance     (bal_out),
		.count       (count),
		.mem_we      (mem_we),
		.wr_addr     (wr_addr),
		.wr_key      (wr_key),
		.wr_bal      (wr_bal),
		.rd_addr     (rd_addr),
		.rd_bal      (rd_bal),
		.ref_key     (ref_key),
		.alu_res     (alu_res)
	);

	assign balance = bal_out;

endmodule

`default_nettype wire

// ===== hw/rtl/kdq_checker.sv =====
// Port-level checks for the keyed deque, bound to the top level.
// Depends on kdq_pkg and keyed_deque_with_search_defines.svh.
`default_nettype none
`include "keyed_deque_with_search_defines.svh"

module kdq_checker
	import kdq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status,
	input logic [BAL_W-1:0]     balance,
	input logic [CNT_OUT_W-1:0] count
);

	localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(CAPACITY);

	// Only found records report a balance
	`KDQ_ASSERT(a_bal_zero, clk, arst_n, !(out_valid && status != STAT_OK && status != STAT_OK) || status == STAT_OK || balance == '0, "nonzero balance on failed request")

	// Full and empty results agree with the reported count
	`KDQ_ASSERT(a_full_cnt, clk, arst_n, !(out_valid && status == STAT_FULL) || count == FULL_CNT, "full status with count below capacity")
	`KDQ_ASSERT(a_empty_cnt, clk, arst_n, !(out_valid && status == STAT_EMPTY) || count == '0, "empty status with records stored")

	// One request at a time: busy right after an accept
	`KDQ_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "request taken while busy")

	// Held result stays put
	`KDQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(balance) && $stable(count), "stalled result changed")

endmodule

bind keyed_deque_with_search kdq_checker #(.CAPACITY(CAPACITY)) u_kdq_checker (.*);

`default_nettype wire
